>>> src/trmc_pkg.sv
package trmc_pkg;

  localparam int unsigned DEF_COLUMNS      = 64;
  localparam int unsigned DEF_ROWS         = 32;
  localparam int unsigned DEF_GLYPH_HEIGHT = 16;

  localparam int unsigned CHAR_AW  = 11;
  localparam int unsigned GLYPH_AW = 12;
  localparam int unsigned LINE_W   = 11;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned COL_W    = 6;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_STOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_STOP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINE     = 3'd5;

  localparam logic [1:0] PWR_ON      = 2'd0;
  localparam logic [1:0] PWR_STANDBY = 2'd1;
  localparam logic [1:0] PWR_SUSPEND = 2'd2;

  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_CHAR_WR  = 2'd1;
  localparam logic [1:0] KIND_GLYPH_WR = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_CHAR_WR  = 2'd1,
    OP_GLYPH_WR = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [GLYPH_AW-1:0] addr;
    logic [PIX_W-1:0]    data;
  } cmd_t;

  typedef struct packed {
    logic             vsync_active;
    logic             hsync_enabled;
    logic             display_on;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixels;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0]        power_mode;
    logic [LINE_W-1:0] vsync_start;
    logic [LINE_W-1:0] vsync_stop;
    logic [LINE_W-1:0] display_start;
    logic [LINE_W-1:0] display_stop;
    logic [LINE_W-1:0] last_line;
  } cfg_t;

endpackage

>>> src/trmc_ram.sv
module trmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/trmc_fifo.sv
module trmc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> src/trmc_front.sv
module trmc_front import trmc_pkg::*; (
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        accept_en_i,
  input  logic        cmd_full_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  assign s_tready_o = accept_en_i && !cmd_full_i;
  assign cmd_push_o = s_tvalid_i && s_tready_o;

  // The character store is half the size of the glyph store, so its
  // address is folded here and the back end sees a ready-made address.
  always_comb begin
    cmd_o.data = s_tdata_i[19:12];
    cmd_o.addr = s_tdata_i[11:0];
    unique case (s_tuser_i)
      KIND_TICK: begin
        cmd_o.op   = OP_TICK;
        cmd_o.addr = '0;
      end
      KIND_CHAR_WR: begin
        cmd_o.op   = OP_CHAR_WR;
        cmd_o.addr = {1'b0, s_tdata_i[CHAR_AW-1:0]};
      end
      KIND_GLYPH_WR: begin
        cmd_o.op = OP_GLYPH_WR;
      end
      KIND_NONE: begin
        cmd_o.op = OP_NOP;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

>>> src/trmc_back.sv
module trmc_back import trmc_pkg::*; #(
  parameter int unsigned COLUMNS      = DEF_COLUMNS,
  parameter int unsigned ROWS         = DEF_ROWS,
  parameter int unsigned GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 cmd_empty_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 accept_en_o,
  input  logic [RES_CNT_W-1:0] res_count_i,
  output logic                 res_push_o,
  output res_t                 res_o
);

  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned GW    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int unsigned SUM_W = GLYPH_AW + 1;
  localparam int unsigned RSV_W = RES_CNT_W + 2;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_STATUS = 5'b00100,
    ST_LINE   = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [GW-1:0]       grow_q, grow_d;
  logic [RW-1:0]       trow_q, trow_d;
  logic                vis_q, vis_d;
  logic                vsync_q, vsync_d;
  logic                hsync_q, hsync_d;
  logic [GLYPH_AW-1:0] clr_q, clr_d;
  logic [CW-1:0]       col_q, col_d;

  logic                s1_valid_q, s2_valid_q;
  logic [CW-1:0]       s1_col_q, s2_col_q;
  logic [GW-1:0]       s1_grow_q;
  logic                s1_last_q, s2_last_q;

  logic                char_we, glyph_we;
  logic [CHAR_AW-1:0]  char_waddr, char_raddr;
  logic [GLYPH_AW-1:0] glyph_waddr, glyph_raddr;
  logic [PIX_W-1:0]    char_wdata, glyph_wdata, char_rdata, glyph_rdata;
  logic [SUM_W-1:0]    ca_full, ga_full;

  logic [RSV_W-1:0]    reserved;
  logic                credit_ok, issue, status_push, last_col, sync_pwr;

  // A result slot is reserved for every column in flight, so the pipeline
  // never has to stall once a read has been issued.
  assign reserved  = RSV_W'(res_count_i) + RSV_W'(s1_valid_q) + RSV_W'(s2_valid_q);
  assign credit_ok = (reserved < RSV_W'(RES_DEPTH));
  assign last_col  = (col_q == CW'(COLUMNS - 1));
  assign sync_pwr  = (cfg_i.power_mode == PWR_ON) || (cfg_i.power_mode == PWR_STANDBY);

  assign ca_full    = SUM_W'(trow_q) * SUM_W'(COLUMNS) + SUM_W'(col_q);
  assign char_raddr = ca_full[CHAR_AW-1:0];
  assign ga_full     = SUM_W'(char_rdata) * SUM_W'(GLYPH_HEIGHT) + SUM_W'(s1_grow_q);
  assign glyph_raddr = ga_full[GLYPH_AW-1:0];

  assign accept_en_o = (state_q != ST_CLEAR);

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    grow_d      = grow_q;
    trow_d      = trow_q;
    vis_d       = vis_q;
    vsync_d     = vsync_q;
    hsync_d     = hsync_q;
    clr_d       = clr_q;
    col_d       = col_q;
    cmd_pop_o   = 1'b0;
    issue       = 1'b0;
    status_push = 1'b0;
    char_we     = 1'b0;
    char_waddr  = cmd_i.addr[CHAR_AW-1:0];
    char_wdata  = cmd_i.data;
    glyph_we    = 1'b0;
    glyph_waddr = cmd_i.addr;
    glyph_wdata = cmd_i.data;

    unique case (state_q)
      ST_CLEAR: begin
        char_we     = 1'b1;
        glyph_we    = 1'b1;
        char_waddr  = clr_q[CHAR_AW-1:0];
        glyph_waddr = clr_q;
        char_wdata  = '0;
        glyph_wdata = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_STATUS;
          unique case (cmd_i.op)
            OP_TICK: begin
              line_d = line_q + 1'b1;
              priority if (line_q == cfg_i.vsync_start) begin
                vsync_d = sync_pwr;
                hsync_d = (cfg_i.power_mode == PWR_ON) ||
                          (cfg_i.power_mode == PWR_SUSPEND);
              end else if (line_q == cfg_i.vsync_stop) begin
                if (sync_pwr) begin
                  vsync_d = 1'b0;
                end
                vis_d  = 1'b0;
                trow_d = '0;
              end else if (line_q == cfg_i.display_start) begin
                vis_d = 1'b1;
              end else if (line_q == cfg_i.display_stop) begin
                vis_d = 1'b0;
              end else if (line_q == cfg_i.last_line) begin
                line_d = '0;
                grow_d = '0;
              end else begin
                line_d = line_q + 1'b1;
              end
              if (vis_d) begin
                state_d = ST_LINE;
              end
            end
            OP_CHAR_WR: begin
              char_we = 1'b1;
            end
            OP_GLYPH_WR: begin
              glyph_we = 1'b1;
            end
            OP_NOP: begin
              state_d = ST_STATUS;
            end
            default: begin
              state_d = ST_STATUS;
            end
          endcase
        end
      end
      ST_STATUS: begin
        if (credit_ok) begin
          status_push = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_LINE: begin
        if (credit_ok) begin
          issue = 1'b1;
          if (last_col) begin
            col_d   = '0;
            state_d = ST_DRAIN;
            if (grow_q == GW'(GLYPH_HEIGHT - 1)) begin
              grow_d = '0;
              trow_d = (trow_q == RW'(ROWS - 1)) ? '0 : trow_q + 1'b1;
            end else begin
              grow_d = grow_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // The next item may write a store, so the reads of this line finish first.
        if (!s1_valid_q && !s2_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      line_q     <= '0;
      grow_q     <= '0;
      trow_q     <= '0;
      vis_q      <= 1'b0;
      vsync_q    <= 1'b0;
      hsync_q    <= 1'b1;
      clr_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      line_q     <= line_d;
      grow_q     <= grow_d;
      trow_q     <= trow_d;
      vis_q      <= vis_d;
      vsync_q    <= vsync_d;
      hsync_q    <= hsync_d;
      clr_q      <= clr_d;
      col_q      <= col_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q  <= col_q;
    s1_grow_q <= grow_q;
    s1_last_q <= last_col;
    s2_col_q  <= s1_col_q;
    s2_last_q <= s1_last_q;
  end

  assign res_push_o       = status_push || s2_valid_q;
  assign res_o.vsync_active  = vsync_q;
  assign res_o.hsync_enabled = hsync_q;
  assign res_o.display_on    = vis_q;
  assign res_o.column = s2_valid_q ? COL_W'(s2_col_q) : '0;
  assign res_o.pixels = s2_valid_q ? glyph_rdata : '0;
  assign res_o.last   = s2_valid_q ? s2_last_q : 1'b1;

  trmc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 ** CHAR_AW)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (char_waddr),
    .wdata_i (char_wdata),
    .raddr_i (char_raddr),
    .rdata_o (char_rdata)
  );

  trmc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 ** GLYPH_AW)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (glyph_waddr),
    .wdata_i (glyph_wdata),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rdata)
  );

endmodule

>>> src/text_mode_raster_controller_unit.sv
// Path: a write or idle-line item goes through the command FIFO, the IDLE and STATUS
// states and the result FIFO before its status item is presented. For a visible line tick
// the column sequencer reads the character and glyph stores once per cycle while result
// space is free; each item is finished before the next one is taken. Reset: asynchronous,
// active low. Afterwards a clearing pass over 4096 addresses zeroes both stores, one entry a
// cycle, and no item is accepted until it ends; registers are written at any time.
module text_mode_raster_controller_unit import trmc_pkg::*; #(
  parameter int unsigned COLUMNS      = DEF_COLUMNS,
  parameter int unsigned ROWS         = DEF_ROWS,
  parameter int unsigned GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // address [11:0], data [19:12]
  input  logic [1:0]            s_axis_tuser,   // kind [1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // vsync_active [0], hsync_enabled [1], display_on [2], column [8:3], pixels [16:9]
  output logic [23:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;

  logic                 cmd_push, cmd_pop, cmd_full, cmd_empty, accept_en;
  logic                 res_push, res_empty;
  logic [RES_CNT_W-1:0] res_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_mode    <= PWR_ON;
      cfg_q.vsync_start   <= LINE_W'(0);
      cfg_q.vsync_stop    <= LINE_W'(2);
      cfg_q.display_start <= LINE_W'(35);
      cfg_q.display_stop  <= LINE_W'(515);
      cfg_q.last_line     <= LINE_W'(524);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POWER_MODE:    cfg_q.power_mode    <= cfg_data_i[1:0];
        CFG_VSYNC_START:   cfg_q.vsync_start   <= cfg_data_i;
        CFG_VSYNC_STOP:    cfg_q.vsync_stop    <= cfg_data_i;
        CFG_DISPLAY_START: cfg_q.display_start <= cfg_data_i;
        CFG_DISPLAY_STOP:  cfg_q.display_stop  <= cfg_data_i;
        CFG_LAST_LINE:     cfg_q.last_line     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  trmc_front u_front (
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .accept_en_i (accept_en),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  trmc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty),
    .count_o ()
  );

  trmc_back #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .accept_en_o (accept_en),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  trmc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (),
    .pop_i   (m_axis_tready),
    .rdata_o (res_out),
    .empty_o (res_empty),
    .count_o (res_count)
  );

  assign m_axis_tvalid = !res_empty;
  assign m_axis_tlast  = res_out.last;
  assign m_axis_tdata  = {7'b0, res_out.pixels, res_out.column, res_out.display_on,
                          res_out.hsync_enabled, res_out.vsync_active};

endmodule

>>> tb/tb_text_mode_raster_controller_unit.sv
`timescale 1ns / 1ps

module tb_text_mode_raster_controller_unit import trmc_pkg::*; ();

  localparam logic [1:0]  PWR_OFF       = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned RANDOM_ITEMS  = 360;

  // Predicts the glyph bytes and status items of the raster controller and
  // checks the output stream against them in order.
  class raster_checker;
    cfg_t              regs;
    logic [LINE_W-1:0] line_cnt;
    int unsigned       glyph_row;
    int unsigned       text_row;
    bit                visible;
    bit                vsync_lvl;
    bit                hsync_ok;
    bit [PIX_W-1:0]    char_mem [1 << CHAR_AW];
    bit [PIX_W-1:0]    glyph_mem [1 << GLYPH_AW];
    res_t              line_results_q [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       ticks;
    int unsigned       lit_lines;

    function new();
      regs.power_mode    = PWR_ON;
      regs.vsync_start   = LINE_W'(0);
      regs.vsync_stop    = LINE_W'(2);
      regs.display_start = LINE_W'(35);
      regs.display_stop  = LINE_W'(515);
      regs.last_line     = LINE_W'(524);
      line_cnt  = '0;
      glyph_row = 0;
      text_row  = 0;
      visible   = 1'b0;
      vsync_lvl = 1'b0;
      hsync_ok  = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_POWER_MODE:    regs.power_mode    = val[1:0];
        CFG_VSYNC_START:   regs.vsync_start   = val;
        CFG_VSYNC_STOP:    regs.vsync_stop    = val;
        CFG_DISPLAY_START: regs.display_start = val;
        CFG_DISPLAY_STOP:  regs.display_stop  = val;
        CFG_LAST_LINE:     regs.last_line     = val;
        default: ;
      endcase
    endfunction

    function void push_result(logic [COL_W-1:0] col, logic [PIX_W-1:0] pix, logic fin);
      res_t r;
      r.vsync_active  = vsync_lvl;
      r.hsync_enabled = hsync_ok;
      r.display_on    = visible;
      r.column        = col;
      r.pixels        = pix;
      r.last          = fin;
      line_results_q.push_back(r);
    endfunction

    function void note_item(op_e op, logic [GLYPH_AW-1:0] addr, logic [PIX_W-1:0] data);
      logic [LINE_W-1:0]   cur;
      logic [CHAR_AW-1:0]  ca;
      logic [GLYPH_AW-1:0] ga;
      case (op)
        OP_CHAR_WR:  char_mem[addr[CHAR_AW-1:0]] = data;
        OP_GLYPH_WR: glyph_mem[addr] = data;
        OP_TICK: begin
          ticks++;
          cur = line_cnt;
          line_cnt = cur + 1'b1;
          // Only the first matching line event fires, so a shadowed last
          // line lets the counter run on to its natural wrap.
          if (cur == regs.vsync_start) begin
            vsync_lvl = (regs.power_mode < PWR_SUSPEND);
            hsync_ok  = (regs.power_mode == PWR_ON || regs.power_mode == PWR_SUSPEND);
          end else if (cur == regs.vsync_stop) begin
            if (regs.power_mode < PWR_SUSPEND) vsync_lvl = 1'b0;
            visible  = 1'b0;
            text_row = 0;
          end else if (cur == regs.display_start) begin
            visible = 1'b1;
          end else if (cur == regs.display_stop) begin
            visible = 1'b0;
          end else if (cur == regs.last_line) begin
            line_cnt  = '0;
            glyph_row = 0;
          end
          if (visible) begin
            lit_lines++;
            for (int c = 0; c < DEF_COLUMNS; c++) begin
              ca = CHAR_AW'(text_row * DEF_COLUMNS + c);
              ga = GLYPH_AW'(char_mem[ca] * DEF_GLYPH_HEIGHT + glyph_row);
              push_result(COL_W'(c), glyph_mem[ga], c == DEF_COLUMNS - 1);
            end
            glyph_row++;
            if (glyph_row >= DEF_GLYPH_HEIGHT) begin
              glyph_row = 0;
              text_row++;
              if (text_row >= DEF_ROWS) text_row = 0;
            end
            return;
          end
        end
        default: ;
      endcase
      push_result('0, '0, 1'b1);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] bus, logic tlast);
      res_t want;
      res_t got;
      got.vsync_active  = bus[0];
      got.hsync_enabled = bus[1];
      got.display_on    = bus[2];
      got.column        = bus[8:3];
      got.pixels        = bus[16:9];
      got.last          = tlast;
      if (line_results_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h last %b", $time, bus, tlast);
        errors++;
        return;
      end
      want = line_results_q.pop_front();
      checked++;
      compare_field("vsync_active", want.vsync_active, got.vsync_active);
      compare_field("hsync_enabled", want.hsync_enabled, got.hsync_enabled);
      compare_field("display_on", want.display_on, got.display_on);
      compare_field("column", want.column, got.column);
      compare_field("pixels", want.pixels, got.pixels);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;   // address [11:0], data [19:12]
  logic [1:0]            s_axis_tuser  = '0;   // kind [1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // vsync_active [0], hsync_enabled [1], display_on [2], column [8:3], pixels [16:9]
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  raster_checker scb;
  bit            src_burst   = 1'b0;
  bit            sink_burst  = 1'b0;
  int unsigned   stall_left  = 0;
  int unsigned   stall_draw;
  int unsigned   cycle_count = 0;
  int unsigned   items_sent  = 0;
  int unsigned   settings    = 0;

  text_mode_raster_controller_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Output side: after each item the receiver may hold off for a random
  // number of cycles, except in burst stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      scb.check_result(m_axis_tdata, m_axis_tlast);
      stall_draw = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      m_axis_tready <= (stall_draw == 0);
      stall_left    <= stall_draw;
    end else if (!m_axis_tready) begin
      m_axis_tready <= (stall_left <= 1);
      stall_left    <= (stall_left <= 1) ? 0 : stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d items still awaited",
               cycle_count, scb.line_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(logic [1:0] pm, int unsigned vs, int unsigned ve,
                                    int unsigned ds, int unsigned de, int unsigned ll);
    cfg_t c;
    c.power_mode    = pm;
    c.vsync_start   = LINE_W'(vs);
    c.vsync_stop    = LINE_W'(ve);
    c.display_start = LINE_W'(ds);
    c.display_stop  = LINE_W'(de);
    c.last_line     = LINE_W'(ll);
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned span;
    span = $urandom_range(2, 20);
    c.power_mode    = 2'($urandom_range(0, 3));
    c.vsync_start   = LINE_W'($urandom_range(0, span + 2));
    c.vsync_stop    = LINE_W'($urandom_range(0, span + 2));
    c.display_start = LINE_W'($urandom_range(0, span + 2));
    c.display_stop  = LINE_W'($urandom_range(0, span + 2));
    // The wrap point mostly sits at or just past the current line, so that short
    // frames start again soon whatever line the counter has reached.
    if (scb.line_cnt < span) c.last_line = LINE_W'(span);
    else c.last_line = scb.line_cnt + LINE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: c.last_line = '1;
      1: c.last_line = LINE_W'(1);
      2: c.display_stop = '1;
      3: c.vsync_start = '0;
      default: ;
    endcase
    if (c.last_line == '0) c.last_line = LINE_W'(1);
    return c;
  endfunction

  // A few codes from both ends of the range, so that glyph writes land on
  // codes that the character store actually holds.
  function automatic logic [PIX_W-1:0] pool_code();
    return PIX_W'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 8'hF8 : 8'h00);
  endfunction

  task automatic write_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx[0] = CFG_POWER_MODE;    val[0] = CFG_DATA_W'(c.power_mode);
    idx[1] = CFG_VSYNC_START;   val[1] = c.vsync_start;
    idx[2] = CFG_VSYNC_STOP;    val[2] = c.vsync_stop;
    idx[3] = CFG_DISPLAY_START; val[3] = c.display_start;
    idx[4] = CFG_DISPLAY_STOP;  val[4] = c.display_stop;
    idx[5] = CFG_LAST_LINE;     val[5] = c.last_line;
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      scb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // tvalid stays high into the next item when no gap is drawn.
  task automatic send_item(input op_e op, input logic [GLYPH_AW-1:0] addr,
                           input logic [PIX_W-1:0] data);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    scb.note_item(op, addr, data);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, GLYPH_AW'($urandom), PIX_W'($urandom));
  endtask

  task automatic send_random();
    int unsigned         pick;
    op_e                 op;
    logic [GLYPH_AW-1:0] addr;
    logic [PIX_W-1:0]    data;
    pick = $urandom_range(0, 99);
    addr = GLYPH_AW'($urandom);
    data = PIX_W'($urandom);
    if (pick < 55) begin
      op = OP_TICK;
    end else if (pick < 75) begin
      op = OP_CHAR_WR;
      // Mostly the first text rows, which short frames actually display.
      if (pick < 68) begin
        addr = {addr[11], 11'($urandom_range(0, 3) * DEF_COLUMNS +
                              $urandom_range(0, DEF_COLUMNS - 1))};
        data = pool_code();
      end
    end else if (pick < 95) begin
      op = OP_GLYPH_WR;
      if (pick < 88) addr = {pool_code(), addr[3:0]};
    end else begin
      op = OP_NOP;
    end
    send_item(op, addr, data);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (scb.line_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    int unsigned phase_len;
    scb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A short frame with the text region at lines 3 to 5.
    write_config(make_cfg(PWR_ON, 0, 2, 3, 6, 7));
    send_item(OP_CHAR_WR, 12'h000, 8'h41);
    send_item(OP_CHAR_WR, 12'h801, 8'hFF);   // address bit 11 folds onto column 1
    send_item(OP_GLYPH_WR, 12'h410, 8'hA5);
    send_item(OP_GLYPH_WR, 12'h411, 8'h5A);
    send_item(OP_GLYPH_WR, 12'hFF0, 8'hFF);
    send_item(OP_NOP, 12'hFFF, 8'hFF);
    repeat (9) send_tick();

    // Display off: vsync and hsync held inactive, text left open past the wrap.
    wait_for_results();
    write_config(make_cfg(PWR_OFF, 1, 2, 3, 2047, 4));
    repeat (5) send_tick();

    // Standby with the smallest frame and a vsync line that is never reached.
    wait_for_results();
    write_config(make_cfg(PWR_STANDBY, 2047, 3, 0, 2, 1));
    send_item(OP_CHAR_WR, 12'hFFF, 8'h00);
    repeat (3) send_tick();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      wait_for_results();
      write_config(random_cfg());
      src_burst = ($urandom_range(0, 3) == 0);
      sink_burst <= ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 45);
      repeat (phase_len) send_random();
    end

    wait_for_results();
    $display("Sent %0d items under %0d register settings: %0d line ticks, %0d lit lines",
             items_sent, settings, scb.ticks, scb.lit_lines);
    $display("Checked %0d output items, %0d mismatches", scb.checked, scb.errors);
    if (scb.errors == 0 && scb.line_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
